@@ design/nec_pkg.sv @@
// ----------------------------------------------------------------------------
// nec_pkg
// Shared types and constants of the note echo generator: field widths,
// register indexes, the fixed-point decay constants and the module links.
// ----------------------------------------------------------------------------
package nec_pkg;

    // Field widths
    localparam int TRACK_W = 8;
    localparam int STEP_W  = 16;
    localparam int VEL_W   = 7;
    localparam int CFG_W   = 7;
    localparam int REP_W   = 7;
    localparam int DATA_W  = 48;

    // Default limit on copies per note
    localparam int MAX_REPEATS_DEF = 64;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEATS = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DELAY_RST   = 7'd24;
    localparam logic [CFG_W-1:0] DECAY_RST   = 7'd50;
    localparam logic [CFG_W-1:0] REPEATS_RST = 7'd3;

    // Decay is a percentage, capped at 100
    localparam logic [CFG_W-1:0] DECAY_MAX = 7'd100;

    // Q1.24 factor
    localparam int FACT_W = 25;
    localparam int FRAC_W = 24;
    localparam logic [FACT_W-1:0] Q_ONE = 25'h100_0000;

    // floor(x / 100) for x below 2^31 as (x * RECIP) >> RECIP_SHIFT
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 64;
    localparam int RECIP_SHIFT = 38;
    localparam logic [MUL_W-1:0] RECIP = 32'd2748779070;

    // Configuration as seen by the sequencer (already clamped)
    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] decay;
        logic [REP_W-1:0] repeats;
    } cfg_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

@@ design/nec_cfg.sv @@
// ----------------------------------------------------------------------------
// nec_cfg
// Configuration registers: delay, decay and repeat count, with the decay
// capped at 100 percent and the repeat count capped at MAX_REPEATS.
// ----------------------------------------------------------------------------
module nec_cfg #(
    parameter int MAX_REPEATS = nec_pkg::MAX_REPEATS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [nec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nec_pkg::CFG_W-1:0]    cfg_wdata,
    output nec_pkg::cfg_t                cfg
);

    localparam logic [nec_pkg::REP_W-1:0] REP_LIMIT = nec_pkg::REP_W'(MAX_REPEATS);

    logic [nec_pkg::CFG_W-1:0] delay_reg;
    logic [nec_pkg::CFG_W-1:0] decay_reg;
    logic [nec_pkg::CFG_W-1:0] repeats_reg;

    // Write one register per enabled cycle; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= nec_pkg::DELAY_RST;
            decay_reg   <= nec_pkg::DECAY_RST;
            repeats_reg <= nec_pkg::REPEATS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                nec_pkg::CFG_DELAY:   delay_reg   <= cfg_wdata;
                nec_pkg::CFG_DECAY:   decay_reg   <= cfg_wdata;
                nec_pkg::CFG_REPEATS: repeats_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Cap decay and repeat count
    always_comb begin
        cfg.delay   = delay_reg;
        cfg.decay   = (decay_reg > nec_pkg::DECAY_MAX) ? nec_pkg::DECAY_MAX : decay_reg;
        cfg.repeats = (repeats_reg > REP_LIMIT) ? REP_LIMIT : repeats_reg;
    end

endmodule

@@ design/nec_mul.sv @@
// ----------------------------------------------------------------------------
// nec_mul
// Shared 32 x 32 multiplier with a registered product, used for the decay
// product, the divide by 100 and the velocity scaling in turn.
// ----------------------------------------------------------------------------
module nec_mul (
    input  logic                          aclk,
    input  nec_pkg::mul_req_t             req,
    output logic [nec_pkg::PROD_W-1:0]    product_reg
);

    logic [nec_pkg::PROD_W-1:0] product_next;

    assign product_next = nec_pkg::PROD_W'(req.a) * nec_pkg::PROD_W'(req.b);

    // Capture the product when requested, hold otherwise
    always_ff @(posedge aclk) begin
        if (req.en) begin
            product_reg <= product_next;
        end
    end

endmodule

@@ design/nec_seq.sv @@
// ----------------------------------------------------------------------------
// nec_seq
// Sequencer: walks the echo copies of one note through the shared
// multiplier, holds one copy back to know its last flag, and drives the
// output register.
// ----------------------------------------------------------------------------
module nec_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Source note
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [nec_pkg::TRACK_W-1:0]       in_track,
    input  logic [nec_pkg::STEP_W-1:0]        in_start,
    input  logic [nec_pkg::STEP_W-1:0]        in_end,
    input  logic [nec_pkg::VEL_W-1:0]         in_vel,
    // Configuration
    input  nec_pkg::cfg_t                     cfg,
    // Shared multiplier
    output nec_pkg::mul_req_t                 mul_req,
    input  logic [nec_pkg::PROD_W-1:0]        product,
    // Echo copies
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [nec_pkg::TRACK_W-1:0]       out_track,
    output logic [nec_pkg::STEP_W-1:0]        out_start,
    output logic [nec_pkg::STEP_W-1:0]        out_end,
    output logic [nec_pkg::VEL_W-1:0]         out_vel,
    output logic                              out_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_RECIP = 6'b000100,
        S_VEL   = 6'b001000,
        S_CHECK = 6'b010000,
        S_LAST  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Source note
    logic [nec_pkg::TRACK_W-1:0] track_reg;
    logic [nec_pkg::STEP_W-1:0]  start_reg;
    logic [nec_pkg::STEP_W-1:0]  end_reg;
    logic [nec_pkg::VEL_W-1:0]   vel0_reg;

    // Iteration state
    logic [nec_pkg::FACT_W-1:0]  factor_reg, factor_next;
    logic [nec_pkg::REP_W-1:0]   k_reg, k_next;
    logic [nec_pkg::STEP_W-1:0]  offset_reg, offset_next;

    // Copy held back until its successor is known
    logic                        pend_valid_reg, pend_valid_next;
    logic [nec_pkg::STEP_W-1:0]  pend_start_reg;
    logic [nec_pkg::STEP_W-1:0]  pend_end_reg;
    logic [nec_pkg::VEL_W-1:0]   pend_vel_reg;
    logic                        pend_load;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [nec_pkg::TRACK_W-1:0] out_track_reg;
    logic [nec_pkg::STEP_W-1:0]  out_start_reg;
    logic [nec_pkg::STEP_W-1:0]  out_end_reg;
    logic [nec_pkg::VEL_W-1:0]   out_vel_reg;
    logic                        out_last_reg, out_last_next;
    logic                        out_load;
    logic                        out_free;

    logic                        accept;
    logic [nec_pkg::FACT_W-1:0]  factor_div;
    logic [nec_pkg::VEL_W-1:0]   vel_now;
    logic [nec_pkg::STEP_W-1:0]  delay_ext;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign factor_div = product[nec_pkg::RECIP_SHIFT +: nec_pkg::FACT_W];
    assign vel_now    = product[nec_pkg::FRAC_W +: nec_pkg::VEL_W];
    assign delay_ext  = nec_pkg::STEP_W'(cfg.delay);

    // Drive the shared multiplier for each step of one copy
    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            S_DEC: begin
                mul_req.en = 1'b1;
                mul_req.a  = nec_pkg::MUL_W'(factor_reg);
                mul_req.b  = nec_pkg::MUL_W'(cfg.decay);
            end
            S_RECIP: begin
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, product[nec_pkg::MUL_W-2:0]};
                mul_req.b  = nec_pkg::RECIP;
            end
            S_VEL: begin
                mul_req.en = 1'b1;
                mul_req.a  = nec_pkg::MUL_W'(factor_div);
                mul_req.b  = nec_pkg::MUL_W'(vel0_reg);
            end
            default: ;
        endcase
    end

    // Sequence the copies
    always_comb begin
        state_next      = state_reg;
        factor_next     = factor_reg;
        k_next          = k_reg;
        offset_next     = offset_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    factor_next     = nec_pkg::Q_ONE;
                    k_next          = nec_pkg::REP_W'(1);
                    offset_next     = delay_ext;
                    pend_valid_next = 1'b0;
                    if (cfg.repeats != '0) begin
                        state_next = S_DEC;
                    end
                end
            end
            S_DEC: begin
                state_next = S_RECIP;
            end
            S_RECIP: begin
                state_next = S_VEL;
            end
            S_VEL: begin
                factor_next = factor_div;
                state_next  = S_CHECK;
            end
            S_CHECK: begin
                if (out_free) begin
                    if (vel_now == '0) begin
                        // Stop: the held copy is the final one
                        out_load      = pend_valid_reg;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end else begin
                        out_load        = pend_valid_reg;
                        out_last_next   = 1'b0;
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        if (k_reg == cfg.repeats) begin
                            state_next = S_LAST;
                        end else begin
                            k_next      = k_reg + nec_pkg::REP_W'(1);
                            offset_next = offset_reg + delay_ext;
                            state_next  = S_DEC;
                        end
                    end
                end
            end
            S_LAST: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, clear when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and iteration registers
    always_ff @(posedge aclk) begin
        factor_reg <= factor_next;
        k_reg      <= k_next;
        offset_reg <= offset_next;
        if (accept) begin
            track_reg <= in_track;
            start_reg <= in_start;
            end_reg   <= in_end;
            vel0_reg  <= in_vel;
        end
        if (pend_load) begin
            pend_start_reg <= start_reg + offset_reg;
            pend_end_reg   <= end_reg + offset_reg;
            pend_vel_reg   <= vel_now;
        end
        if (out_load) begin
            out_track_reg <= track_reg;
            out_start_reg <= pend_start_reg;
            out_end_reg   <= pend_end_reg;
            out_vel_reg   <= pend_vel_reg;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_track = out_track_reg;
    assign out_start = out_start_reg;
    assign out_end   = out_end_reg;
    assign out_vel   = out_vel_reg;
    assign out_last  = out_last_reg;

endmodule

@@ design/note_echo_generator_core.sv @@
// ----------------------------------------------------------------------------
// note_echo_generator_core
// Echo copies of one sequencer note, shifted in time and decayed in velocity.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one source note per word. For each note the block sends
//   up to echo_repeats words on the m_ channel, copy k shifted by k times
//   echo_delay steps (wrapping at 65536) with velocity scaled by
//   (echo_decay/100)^k in Q1.24. The run stops at the first copy whose
//   velocity would be zero; the final copy sent carries m_tlast.
//   Configuration: cfg_wr_en with cfg_index 0 delay, 1 decay, 2 repeats;
//   write only while no note is in progress.
//   Timing: each copy passes through the decay product, the divide by 100
//   and the velocity scaling on the shared multiplier, then a check. Each
//   copy is held back until the next one is worked out or the run ends, so
//   that its last flag is known. s_tready is low while the copies of a
//   note are being worked out.
//   Stall: a stalled receiver holds the current word in the output register
//   and the sequencer waits at the next copy; nothing is dropped.
//   Reset: aresetn, synchronous active low, returns the registers to
//   delay 24, decay 50, repeats 3 and empties the output.
// ----------------------------------------------------------------------------
module note_echo_generator_core #(
    parameter int MAX_REPEATS = nec_pkg::MAX_REPEATS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Source notes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // track_number[7:0], note_start[23:8], note_end[39:24],
    // note_velocity[46:40], zero [47]
    input  logic [nec_pkg::DATA_W-1:0]    s_tdata,
    // Echo copies
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // echo_track[7:0], echo_start[23:8], echo_end[39:24],
    // echo_velocity[46:40], zero [47]
    output logic [nec_pkg::DATA_W-1:0]    m_tdata,
    // last_echo
    output logic                          m_tlast,
    // Configuration writes
    input  logic                          cfg_wr_en,
    input  logic [nec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nec_pkg::CFG_W-1:0]     cfg_wdata
);

    nec_pkg::cfg_t              cfg;
    nec_pkg::mul_req_t          mul_req;
    logic [nec_pkg::PROD_W-1:0] product;

    logic [nec_pkg::TRACK_W-1:0] out_track;
    logic [nec_pkg::STEP_W-1:0]  out_start;
    logic [nec_pkg::STEP_W-1:0]  out_end;
    logic [nec_pkg::VEL_W-1:0]   out_vel;

    nec_cfg #(
        .MAX_REPEATS (MAX_REPEATS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nec_mul u_mul (
        .aclk        (aclk),
        .req         (mul_req),
        .product_reg (product)
    );

    nec_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_track  (s_tdata[7:0]),
        .in_start  (s_tdata[23:8]),
        .in_end    (s_tdata[39:24]),
        .in_vel    (s_tdata[46:40]),
        .cfg       (cfg),
        .mul_req   (mul_req),
        .product   (product),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_track (out_track),
        .out_start (out_start),
        .out_end   (out_end),
        .out_vel   (out_vel),
        .out_last  (m_tlast)
    );

    // Pack the output word, lowest field first
    assign m_tdata = {1'b0, out_vel, out_end, out_start, out_track};

endmodule

@@ design/nec_checker.sv @@
// ----------------------------------------------------------------------------
// nec_checker
// Port-level checks on the note echo generator: output hold under stall,
// non-zero velocities and run framing.
// ----------------------------------------------------------------------------
module nec_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [nec_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // Hold a stalled word
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // An emitted copy never has zero velocity
    a_vel_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[46:40] != 7'd0)
        else $error("echo with zero velocity");

    // Once ready for a new note, any word still waiting closes its run
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("block idle with an unfinished run on the output");

endmodule

bind note_echo_generator_core nec_checker u_nec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for note_echo_generator_core. Source notes go in on
// the s_ stream and echo copies are checked on the m_ stream. Each note is
// checked against a bit-true echo predictor running on a shadow copy of the
// registers. A short directed table covers the field extremes, register
// clamping, ignored writes and the cases that give no copies. Random phases
// with fresh register settings follow, with bursts of sender gaps and
// receiver stalls. The last phase runs with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 10;
    localparam int NOTES_PER_PHASE = 50;

    localparam logic [nec_pkg::CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [nec_pkg::REP_W-1:0]     COPY_LIMIT    = 7'd64;
    localparam logic [31:0]                   DECAY_DIVISOR = 32'd100;
    localparam logic [nec_pkg::VEL_W-1:0]     VEL_MAX       = 7'd127;

    typedef enum logic {ROW_CFG, ROW_NOTE} row_kind_t;

    // One row of the directed table: a register write or a source note
    typedef struct packed {
        row_kind_t                     kind;
        logic [nec_pkg::CFG_IDX_W-1:0] reg_index;
        logic [nec_pkg::CFG_W-1:0]     reg_value;
        logic [nec_pkg::TRACK_W-1:0]   track;
        logic [nec_pkg::STEP_W-1:0]    start;
        logic [nec_pkg::STEP_W-1:0]    stop;
        logic [nec_pkg::VEL_W-1:0]     velocity;
        logic                          typed;
        logic [nec_pkg::REP_W-1:0]     copies;
        logic [nec_pkg::VEL_W-1:0]     lead_vel;
    } row_t;

    // One echo copy as seen on the m_ stream
    typedef struct packed {
        logic [nec_pkg::TRACK_W-1:0] track;
        logic [nec_pkg::STEP_W-1:0]  start;
        logic [nec_pkg::STEP_W-1:0]  stop;
        logic [nec_pkg::VEL_W-1:0]   velocity;
        logic                        last;
    } echo_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [nec_pkg::DATA_W-1:0]    s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [nec_pkg::DATA_W-1:0]    m_tdata;
    logic                          m_tlast;
    logic                          cfg_wr_en = 1'b0;
    logic [nec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nec_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // Hand-worked expectation travelling beside the note being offered
    logic                          typed_on     = 1'b0;
    logic [nec_pkg::REP_W-1:0]     typed_copies = '0;
    logic [nec_pkg::VEL_W-1:0]     typed_lead   = '0;

    // Shadow registers and the store of copies still to come
    logic [nec_pkg::CFG_W-1:0]     echo_delay_q;
    logic [nec_pkg::CFG_W-1:0]     echo_decay_q;
    logic [nec_pkg::REP_W-1:0]     echo_repeats_q;
    echo_t                         pending_echoes[$];

    int unsigned          fail_count   = 0;
    int unsigned          quiet_cycles = 0;
    bit                   gaps_on      = 1'b0;
    logic                 stalls_on    = 1'b0;
    int unsigned          stall_left   = 0;
    row_t                 directed_rows[$];

    note_echo_generator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Work out every copy of one note, queue them and report count and lead velocity
    function automatic int unsigned predict_echoes(
        input  logic [nec_pkg::DATA_W-1:0] note,
        output logic [nec_pkg::VEL_W-1:0]  lead_vel);
        logic [nec_pkg::TRACK_W-1:0] trk;
        logic [nec_pkg::STEP_W-1:0]  st;
        logic [nec_pkg::STEP_W-1:0]  sp;
        logic [nec_pkg::STEP_W-1:0]  offset;
        logic [nec_pkg::VEL_W-1:0]   v0;
        logic [nec_pkg::VEL_W-1:0]   vel;
        logic [nec_pkg::CFG_W-1:0]   decay;
        logic [nec_pkg::REP_W-1:0]   reps;
        logic [nec_pkg::FACT_W-1:0]  factor;
        logic [31:0]                 scaled;
        int unsigned                 k;
        int unsigned                 copies;
        trk    = note[7:0];
        st     = note[23:8];
        sp     = note[39:24];
        v0     = note[46:40];
        decay  = (echo_decay_q > nec_pkg::DECAY_MAX) ? nec_pkg::DECAY_MAX : echo_decay_q;
        reps   = (echo_repeats_q > COPY_LIMIT) ? COPY_LIMIT : echo_repeats_q;
        factor = nec_pkg::Q_ONE;
        copies = 0;
        lead_vel = '0;
        for (k = 1; k <= reps; k++) begin
            // decay the Q1.24 factor, truncating, then scale the source velocity
            scaled = 32'(factor) * 32'(decay);
            factor = nec_pkg::FACT_W'(scaled / DECAY_DIVISOR);
            scaled = (32'(v0) * 32'(factor)) >> nec_pkg::FRAC_W;
            if (scaled == 0)
                break;
            vel    = (scaled > 32'(VEL_MAX)) ? VEL_MAX : nec_pkg::VEL_W'(scaled);
            offset = nec_pkg::STEP_W'(k * echo_delay_q);
            pending_echoes.push_back('{trk, nec_pkg::STEP_W'(st + offset),
                                       nec_pkg::STEP_W'(sp + offset), vel, 1'b0});
            if (copies == 0)
                lead_vel = vel;
            copies++;
        end
        if (copies != 0)
            pending_echoes[$].last = 1'b1;
        return copies;
    endfunction

    function automatic row_t cfg_row(input logic [nec_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [nec_pkg::CFG_W-1:0] val);
        row_t r;
        r           = '0;
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    function automatic row_t note_row(input logic [nec_pkg::TRACK_W-1:0] trk,
                                      input logic [nec_pkg::STEP_W-1:0] st,
                                      input logic [nec_pkg::STEP_W-1:0] sp,
                                      input logic [nec_pkg::VEL_W-1:0] vel,
                                      input logic typed,
                                      input logic [nec_pkg::REP_W-1:0] copies,
                                      input logic [nec_pkg::VEL_W-1:0] lead);
        row_t r;
        r          = '0;
        r.kind     = ROW_NOTE;
        r.track    = trk;
        r.start    = st;
        r.stop     = sp;
        r.velocity = vel;
        r.typed    = typed;
        r.copies   = copies;
        r.lead_vel = lead;
        return r;
    endfunction

    // Hold until every predicted copy has been taken
    task automatic wait_all_echoes();
        do @(posedge aclk); while (pending_echoes.size() != 0);
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(input logic [nec_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nec_pkg::CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        wait_all_echoes();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one source note, with an optional gap first, and hold it until taken
    task automatic send_note(input logic [nec_pkg::TRACK_W-1:0] trk,
                             input logic [nec_pkg::STEP_W-1:0] st,
                             input logic [nec_pkg::STEP_W-1:0] sp,
                             input logic [nec_pkg::VEL_W-1:0] vel,
                             input logic typed, input logic [nec_pkg::REP_W-1:0] copies,
                             input logic [nec_pkg::VEL_W-1:0] lead);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= {1'b0, vel, sp, st, trk};
        typed_on     <= typed;
        typed_copies <= copies;
        typed_lead   <= lead;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Receiver: drop m_tready in bursts of random length while stalls are enabled
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Track register writes, predict accepted notes, check copies, watch for a hang
    always @(posedge aclk) begin : scoreboard
        int unsigned               produced;
        logic [nec_pkg::VEL_W-1:0] lead_vel;
        echo_t                     seen;
        echo_t                     want;
        if (!aresetn) begin
            echo_delay_q   = nec_pkg::DELAY_RST;
            echo_decay_q   = nec_pkg::DECAY_RST;
            echo_repeats_q = nec_pkg::REPEATS_RST;
            quiet_cycles   = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    nec_pkg::CFG_DELAY:   echo_delay_q   = cfg_wdata;
                    nec_pkg::CFG_DECAY:   echo_decay_q   = cfg_wdata;
                    nec_pkg::CFG_REPEATS: echo_repeats_q = cfg_wdata;
                    default: ;
                endcase
            end

            // predict first: a copy never leaves in the cycle its note is taken
            if (s_tvalid && s_tready) begin
                produced = predict_echoes(s_tdata, lead_vel);
                if (typed_on && (produced != typed_copies ||
                                 (produced != 0 && lead_vel != typed_lead))) begin
                    fail_count++;
                    $display("%0t: note %h: expected %0d copies, lead velocity %0d;",
                             $time, s_tdata, typed_copies, typed_lead);
                    $display("%0t:   got %0d copies, lead velocity %0d",
                             $time, produced, lead_vel);
                end
            end

            if (m_tvalid && m_tready) begin
                seen = '{m_tdata[7:0], m_tdata[23:8], m_tdata[39:24], m_tdata[46:40],
                         m_tlast};
                if (pending_echoes.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected copy: expected none, got trk %0d start %0d",
                             $time, seen.track, seen.start);
                    $display("%0t:   end %0d vel %0d last %0d",
                             $time, seen.stop, seen.velocity, seen.last);
                end else begin
                    want = pending_echoes.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        $display("%0t: copy mismatch: expected trk %0d start %0d end %0d",
                                 $time, want.track, want.start, want.stop);
                        $display("%0t:   expected vel %0d last %0d",
                                 $time, want.velocity, want.last);
                        $display("%0t:   got trk %0d start %0d end %0d vel %0d last %0d",
                                 $time, seen.track, seen.start, seen.stop,
                                 seen.velocity, seen.last);
                    end
                end
            end

            // count cycles in which nothing moves at all
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles, %0d copies outstanding",
                             $time, quiet_cycles, pending_echoes.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned                p;
        int unsigned                i;
        int unsigned                pick;
        logic [nec_pkg::STEP_W-1:0] st;
        logic [nec_pkg::CFG_W-1:0]  decay_val;
        logic [nec_pkg::REP_W-1:0]  reps_val;

        // Directed table; expected copies and lead velocity typed where obvious
        directed_rows = '{
            // reset settings: 50, 25, 12
            note_row(8'd0,   16'd0,     16'd0,     7'd100, 1'b1, 7'd3,  7'd50),
            // all fields at their top, start and end wrap
            note_row(8'd255, 16'hFFFF,  16'hFFFF,  7'd127, 1'b1, 7'd3,  7'd63),
            // silent source
            note_row(8'h5A,  16'd100,   16'd200,   7'd0,   1'b1, 7'd0,  7'd0),
            // first copy floors to zero
            note_row(8'h01,  16'd7,     16'd9,     7'd1,   1'b1, 7'd0,  7'd0),
            // write to an unknown index must change nothing
            cfg_row(CFG_UNUSED, 7'd127),
            note_row(8'h80,  16'h8000,  16'h7FFF,  7'd100, 1'b1, 7'd3,  7'd50),
            // decay above 100 acts as 100, repeats clamp to the limit, widest delay
            cfg_row(nec_pkg::CFG_DECAY,   7'd127),
            cfg_row(nec_pkg::CFG_REPEATS, 7'd127),
            cfg_row(nec_pkg::CFG_DELAY,   7'd127),
            note_row(8'h3C,  16'hFF00,  16'hFFFF,  7'd1,   1'b1, 7'd64, 7'd1),
            note_row(8'hA5,  16'hFFFF,  16'h8000,  7'd127, 1'b1, 7'd64, 7'd127),
            // zero decay silences everything
            cfg_row(nec_pkg::CFG_DECAY,   7'd0),
            note_row(8'hFF,  16'h0000,  16'hFFFF,  7'd127, 1'b1, 7'd0,  7'd0),
            // zero repeats
            cfg_row(nec_pkg::CFG_DECAY,   7'd100),
            cfg_row(nec_pkg::CFG_REPEATS, 7'd0),
            note_row(8'h0F,  16'h1234,  16'h1300,  7'd127, 1'b1, 7'd0,  7'd0),
            // single copy, no shift
            cfg_row(nec_pkg::CFG_REPEATS, 7'd1),
            cfg_row(nec_pkg::CFG_DELAY,   7'd0),
            note_row(8'hF0,  16'd1234,  16'd1300,  7'd127, 1'b1, 7'd1,  7'd127),
            // long slow decay
            cfg_row(nec_pkg::CFG_DELAY,   7'd96),
            cfg_row(nec_pkg::CFG_DECAY,   7'd99),
            cfg_row(nec_pkg::CFG_REPEATS, 7'd64),
            note_row(8'h33,  16'hFFA0,  16'hFFF0,  7'd127, 1'b0, 7'd0,  7'd0),
            // steep decay
            cfg_row(nec_pkg::CFG_DECAY,   7'd1),
            cfg_row(nec_pkg::CFG_REPEATS, 7'd5),
            note_row(8'hCC,  16'h0001,  16'h0002,  7'd127, 1'b0, 7'd0,  7'd0),
            cfg_row(nec_pkg::CFG_DECAY,   7'd63),
            note_row(8'h12,  16'h5555,  16'hAAAA,  7'd64,  1'b0, 7'd0,  7'd0)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
            end else begin
                send_note(directed_rows[r].track, directed_rows[r].start,
                          directed_rows[r].stop, directed_rows[r].velocity,
                          directed_rows[r].typed, directed_rows[r].copies,
                          directed_rows[r].lead_vel);
            end
        end

        // Random phases, each with fresh settings; mostly few copies per note
        for (p = 0; p < NUM_PHASES; p++) begin
            pick      = $urandom_range(0, 9);
            decay_val = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd100 : (pick == 2) ? 7'd127 :
                        nec_pkg::CFG_W'($urandom_range(30, 99));
            pick      = $urandom_range(0, 9);
            reps_val  = (pick == 0) ? 7'd64 : (pick == 1) ? 7'd127 : (pick == 2) ? 7'd0 :
                        nec_pkg::REP_W'($urandom_range(1, 8));
            write_reg(nec_pkg::CFG_DELAY,
                      ($urandom_range(0, 3) == 0) ? 7'd96 : nec_pkg::CFG_W'($urandom));
            write_reg(nec_pkg::CFG_DECAY, decay_val);
            write_reg(nec_pkg::CFG_REPEATS, reps_val);

            // idle on neither, one or both sides; the final phase runs flat out
            pick       = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 3);
            gaps_on    = pick[0];
            stalls_on <= pick[1];

            for (i = 0; i < NOTES_PER_PHASE; i++) begin
                if (p != NUM_PHASES - 1 && $urandom_range(0, 31) == 0) begin
                    s_tvalid <= 1'b0;
                    wait_all_echoes();
                end
                st = ($urandom_range(0, 7) == 0)
                   ? 16'hFFFF - nec_pkg::STEP_W'($urandom_range(0, 255))
                   : nec_pkg::STEP_W'($urandom);
                send_note(nec_pkg::TRACK_W'($urandom), st, nec_pkg::STEP_W'($urandom),
                          ($urandom_range(0, 15) == 0) ? 7'd0 : nec_pkg::VEL_W'($urandom),
                          1'b0, '0, '0);
            end
        end

        // Drain, let the block settle, then report
        s_tvalid <= 1'b0;
        wait_all_echoes();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_echoes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
